>>> design/drude_lorentz_permittivity_macros.svh
// Assertion macros shared by the Drude-Lorentz permittivity block.
// Included by the top level; holds nothing but macro definitions.
`ifndef DRUDE_LORENTZ_PERMITTIVITY_MACROS_SVH
`define DRUDE_LORENTZ_PERMITTIVITY_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DLP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dlp_pkg.sv
// Package for the Drude-Lorentz permittivity block: sizes, register indexes,
// sequencer states and the Q16.16 saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dlp_pkg;
  localparam int DLP_MAX_OSC = 16;
  localparam logic [1:0] REG_EPS_INF = 2'd0;
  localparam logic [1:0] REG_PLASMA = 2'd1;
  localparam logic [1:0] REG_DAMPING = 2'd2;
  localparam logic [1:0] REG_OSC_COUNT = 2'd3;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_E2, ST_G2, ST_DDEN, ST_P2, ST_IDEN, ST_DCHK, ST_DRE, ST_NUM1, ST_NUM2,
    ST_DIM, ST_RD, ST_RDW, ST_K2, ST_D, ST_DD, ST_GG, ST_GGE, ST_DEN, ST_FK2,
    ST_NRE, ST_ORE, ST_NI1, ST_NI2, ST_OIM, ST_DIVW, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage
`default_nettype wire

>>> design/dlp_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/dlp_div.sv
// Iterative signed Q16.16 divider: (num*65536)/den, truncated, saturated.
// One quotient bit per cycle, 48 quotient bits in all. Depends on dlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlp_div
  import dlp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire div_req_t     req,
  output logic              busy,
  output logic              done,
  output logic signed [31:0] quot
);
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [47:0] q;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [33:0] trial;
  logic [48:0] qs;

  assign trial = {rem, dvd[47]} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
        dvd  <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'b0};
        dvs  <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        neg  <= req.num[31] ^ req.den[31];
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[47]};
          q   <= {q[46:0], 1'b0};
        end
        dvd <= {dvd[46:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qs = neg ? -{1'b0, q} : {1'b0, q};
    quot = sat32(66'(signed'(qs)));
  end
endmodule
`default_nettype wire

>>> design/drude_lorentz_permittivity.sv
// Drude-Lorentz permittivity evaluator, Q16.16, one shared multiplier and divider.
// A write item is taken at once. An evaluate item holds busy while the terms of its n
// oscillators are formed with the 48-step shared divider, two divides per term. The
// result strobe comes as busy falls; there is no receiver stall.
// Synchronous active-high reset restores the register defaults; tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "drude_lorentz_permittivity_macros.svh"
module drude_lorentz_permittivity
  import dlp_pkg::*;
#(
  parameter int MAX_OSCILLATORS = DLP_MAX_OSC
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation,
  input  wire logic [3:0]          entry_index,
  input  wire logic signed [31:0]  center_energy,
  input  wire logic signed [31:0]  strength,
  input  wire logic signed [31:0]  width,
  input  wire logic [30:0]         photon_energy,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output logic                     result_valid,
  output logic signed [31:0]       real_part,
  output logic signed [31:0]       imag_part,
  output logic                     fault
);
  localparam int AW = (MAX_OSCILLATORS > 1) ? $clog2(MAX_OSCILLATORS) : 1;

  logic signed [31:0] eps_infinity, plasma_energy, drude_damping;
  logic [4:0] oscillator_count;
  state_t state, state_next, ret, ret_next;
  logic signed [31:0] e, e2, g2, dden, p2, iden, t1, t2, k2, d, fk2;
  logic signed [31:0] ek, fk, gk;
  logic signed [31:0] ma, mb, mq;
  logic signed [63:0] mp;
  logic signed [40:0] acc_re, acc_im;
  logic [6:0] k;
  logic [6:0] nterms;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] rd_c, rd_f, rd_w;
  div_req_t dreq;
  logic dbusy, ddone;
  logic signed [31:0] dq;
  logic is_re;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign we = start && !busy && operation == OP_WRITE && 32'(entry_index) < MAX_OSCILLATORS;
  assign waddr = AW'(entry_index);
  assign raddr = AW'(k);
  assign nterms = (32'(oscillator_count) > MAX_OSCILLATORS) ? 7'(MAX_OSCILLATORS)
                                                             : 7'(oscillator_count);

  dlp_ram #(.WIDTH(32), .DEPTH(MAX_OSCILLATORS)) u_c (
    .clk, .we, .waddr, .wdata(center_energy), .raddr, .rdata(rd_c));
  dlp_ram #(.WIDTH(32), .DEPTH(MAX_OSCILLATORS)) u_f (
    .clk, .we, .waddr, .wdata(strength), .raddr, .rdata(rd_f));
  dlp_ram #(.WIDTH(32), .DEPTH(MAX_OSCILLATORS)) u_w (
    .clk, .we, .waddr, .wdata(width), .raddr, .rdata(rd_w));

  dlp_div u_div (.clk, .rst, .req(dreq), .busy(dbusy), .done(ddone), .quot(dq));

  // Shared multiplier: operands picked by state, product truncated and saturated.
  always_comb begin
    ma = e;
    mb = e;
    case (state)
      ST_G2:   begin ma = drude_damping; mb = drude_damping; end
      ST_P2:   begin ma = plasma_energy; mb = plasma_energy; end
      ST_IDEN: begin ma = e2; mb = dden; end
      ST_NUM1: begin ma = p2; mb = drude_damping; end
      ST_NUM2: begin ma = t1; mb = e; end
      ST_K2:   begin ma = ek; mb = ek; end
      ST_DD:   begin ma = d; mb = d; end
      ST_GG:   begin ma = gk; mb = gk; end
      ST_GGE:  begin ma = t2; mb = e2; end
      ST_FK2:  begin ma = fk; mb = k2; end
      ST_NRE:  begin ma = fk2; mb = d; end
      ST_NI1:  begin ma = fk2; mb = gk; end
      ST_NI2:  begin ma = t1; mb = e; end
      default: begin ma = e; mb = e; end
    endcase
    mp = ma * mb;
    mq = sat32(66'(mp / 64'sd65536));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    case (state)
      ST_IDLE: if (start && operation == OP_EVAL) state_next = ST_E2;
      ST_E2:   state_next = ST_G2;
      ST_G2:   state_next = ST_DDEN;
      ST_DDEN: state_next = ST_P2;
      ST_P2:   state_next = ST_IDEN;
      ST_IDEN: state_next = ST_DCHK;
      ST_DCHK: state_next = (dden == 0 || iden == 0) ? ST_DONE : ST_DRE;
      ST_DRE: begin
        ret_next = ST_NUM1;
        state_next = ST_DIVW;
      end
      ST_NUM1: state_next = ST_NUM2;
      ST_NUM2: state_next = ST_DIM;
      ST_DIM: begin
        ret_next = ST_RD;
        state_next = ST_DIVW;
      end
      ST_RD:   state_next = (k < nterms) ? ST_RDW : ST_DONE;
      ST_RDW:  state_next = ST_K2;
      ST_K2:   state_next = ST_D;
      ST_D:    state_next = ST_DD;
      ST_DD:   state_next = ST_GG;
      ST_GG:   state_next = ST_GGE;
      ST_GGE:  state_next = ST_DEN;
      ST_DEN:  state_next = ST_FK2;
      ST_FK2:  state_next = (t1 == 0) ? ST_DONE : ST_NRE;
      ST_NRE:  state_next = ST_ORE;
      ST_ORE: begin
        ret_next = ST_NI1;
        state_next = ST_DIVW;
      end
      ST_NI1:  state_next = ST_NI2;
      ST_NI2:  state_next = ST_OIM;
      ST_OIM: begin
        ret_next = ST_RD;
        state_next = ST_DIVW;
      end
      ST_DIVW: if (ddone) state_next = ret;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq = '0;
    case (state)
      ST_DRE:         dreq = '{start: 1'b1, num: p2, den: dden};
      ST_DIM:         dreq = '{start: 1'b1, num: t1, den: iden};
      ST_ORE, ST_OIM: dreq = '{start: 1'b1, num: t1, den: t2};
      default: ;
    endcase
  end

  // Datapath registers. In the oscillator loop t1 carries den until fk2 is
  // formed, then the numerators; t2 keeps den for both divides.
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_infinity <= 32'sd65536;
      plasma_energy <= '0;
      drude_damping <= '0;
      oscillator_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EPS_INF:   eps_infinity <= cfg_data;
          REG_PLASMA:    plasma_energy <= cfg_data;
          REG_DAMPING:   drude_damping <= cfg_data;
          REG_OSC_COUNT: oscillator_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state == ST_DONE) result_valid <= 1'b1;
    end
    ret <= ret_next;
    case (state)
      ST_IDLE: begin
        e <= {1'b0, photon_energy};
        k <= '0;
        fault <= 1'b0;
      end
      ST_E2:   e2 <= mq;
      ST_G2:   g2 <= mq;
      ST_DDEN: dden <= sat32(66'(e2) + 66'(g2));
      ST_P2:   p2 <= mq;
      ST_IDEN: begin
        iden <= mq;
        acc_re <= 41'(eps_infinity);
        acc_im <= '0;
      end
      ST_DCHK: if (dden == 0 || iden == 0) fault <= 1'b1;
      ST_DRE:  is_re <= 1'b1;
      ST_NUM1: t1 <= mq;
      ST_NUM2: t1 <= mq;
      ST_DIM:  is_re <= 1'b0;
      // The oscillator's entries are already latched, so the slot can move on.
      ST_OIM: begin
        is_re <= 1'b0;
        k <= k + 7'd1;
      end
      ST_ORE: is_re <= 1'b1;
      ST_RDW: begin
        ek <= rd_c;
        fk <= rd_f;
        gk <= rd_w;
      end
      ST_K2:   k2 <= mq;
      ST_D:    d <= sat32(66'(k2) - 66'(e2));
      ST_DD:   t1 <= mq;
      ST_GG:   t2 <= mq;
      ST_GGE:  t2 <= mq;
      ST_DEN:  t1 <= sat32(66'(t1) + 66'(t2));
      ST_FK2: begin
        fk2 <= mq;
        t2 <= t1;
        if (t1 == 0) fault <= 1'b1;
      end
      ST_NRE:  t1 <= mq;
      ST_NI1:  t1 <= mq;
      ST_NI2:  t1 <= mq;
      ST_DIVW: if (ddone) begin
        if (ret == ST_NUM1) acc_re <= acc_re - 41'(dq);
        else if (is_re) acc_re <= acc_re + 41'(dq);
        else acc_im <= acc_im + 41'(dq);
      end
      ST_DONE: begin
        real_part <= fault ? 32'sd0 : sat32(66'(acc_re));
        imag_part <= fault ? 32'sd0 : sat32(66'(acc_im));
      end
      default: ;
    endcase
  end

  `DLP_ASSERT_NEXT(a_div_start_idle, clk, rst, dreq.start, dbusy, "divider did not start")
  `DLP_ASSERT_IMPLY(a_no_strobe_busy, clk, rst, result_valid, state == ST_IDLE, "strobe while busy")
  `DLP_ASSERT_IMPLY(a_fault_zero, clk, rst, result_valid && fault,
    real_part == 0 && imag_part == 0, "fault with nonzero result")
endmodule
`default_nettype wire
